// ----- hdl/mbe_pkg.sv -----
// Package: types, constants and helpers for the Mandelbrot escape counter.
package mbe_pkg;

  localparam int FRAC_BITS = 28;

  localparam logic signed [31:0] RST_X_ORIGIN = 32'(-(5 * 2 ** (FRAC_BITS - 1)));
  localparam logic [30:0]        RST_X_STEP   = 31'(7 * 2 ** (FRAC_BITS - 6));
  localparam logic signed [31:0] RST_Y_ORIGIN = 32'(-(2 ** FRAC_BITS));
  localparam logic [30:0]        RST_Y_STEP   = 31'((2 * 2 ** FRAC_BITS) / 22);
  localparam logic [7:0]         RST_MAX_ITER = 8'd15;

  localparam logic [63:0] MAG_LIMIT = 64'd4 << (2 * FRAC_BITS);

  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_X_STEP   = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] iteration_count;
    logic       escaped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAPX,
    ST_MAPY,
    ST_MAPC,
    ST_MXX,
    ST_MYY,
    ST_MXY,
    ST_UPD
  } state_t;

  typedef enum logic [2:0] {
    MOP_COLX,
    MOP_ROWY,
    MOP_XX,
    MOP_YY,
    MOP_XY
  } mul_op_t;

  typedef struct packed {
    logic    idle;
    logic    load_item;
    mul_op_t mul_op;
    logic    cap_cr;
    logic    cap_ci;
    logic    cap_xx;
    logic    cap_diff;
    logic    upd_en;
    logic    finish;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/mbe_mul.sv -----
// Shared signed 32x32 multiplier with registered 64-bit product.
module mbe_mul import mbe_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule

// ----- hdl/mbe_ctrl.sv -----
// Sequencer: steps the shared multiplier through mapping and iterations.
module mbe_ctrl import mbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic done,
  input  logic out_free,
  output ctl_t ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MAPX;
      end
      ST_MAPX: state_nxt = ST_MAPY;
      ST_MAPY: state_nxt = ST_MAPC;
      ST_MAPC: state_nxt = ST_MYY;
      ST_MXX:  state_nxt = ST_MYY;
      ST_MYY:  state_nxt = ST_MXY;
      ST_MXY:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (!done) begin
          state_nxt = ST_MXX;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mul_op = MOP_XX;
    unique case (state_r)
      ST_IDLE: begin
        ctl.idle      = 1'b1;
        ctl.load_item = in_valid;
      end
      ST_MAPX: ctl.mul_op = MOP_COLX;
      ST_MAPY: begin
        ctl.mul_op = MOP_ROWY;
        ctl.cap_cr = 1'b1;
      end
      ST_MAPC: begin
        ctl.mul_op = MOP_XX;
        ctl.cap_ci = 1'b1;
      end
      ST_MXX: ctl.mul_op = MOP_XX;
      ST_MYY: begin
        ctl.mul_op = MOP_YY;
        ctl.cap_xx = 1'b1;
      end
      ST_MXY: begin
        ctl.mul_op   = MOP_XY;
        ctl.cap_diff = 1'b1;
      end
      ST_UPD: begin
        ctl.upd_en = !done;
        ctl.finish = done && out_free;
      end
      default: ctl.idle = 1'b0;
    endcase
  end

endmodule

// ----- hdl/mandelbrot_escape_count_core.sv -----
// Top level: Mandelbrot escape-time counter with one shared multiplier.
//
// Input channel in_*: one item is a pixel column and row; it is taken when
// in_valid is high and in_stall is low. in_stall is high from the cycle
// after an item is taken until its result has been written to the output
// register, so one pixel is worked on at a time.
// Output channel out_*: one item per pixel, the iteration count and the
// escape flag, held in an output register until taken (out_valid high and
// out_stall low). A new pixel can be taken while that result still waits.
// The single 32x32 multiplier forms every product: mapping issues the two
// products column*x_step and row*y_step, its last step also issuing the
// first x*x, and each pass issues x*x, y*y and x*y and then updates, the
// first pass without its own x*x step. With n iterations there are n+1
// passes, the last one only checking, and the next pixel can be taken as
// soon as the result has been written to the output register.
// If out_stall holds the previous result, the finished pixel waits in its
// last step. cfg_* writes a register at any edge with cfg_we high; writes
// are expected only while idle. Reset clears the control state, drops any
// pending result and loads the default view and limit.
module mandelbrot_escape_count_core import mbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  ctl_t ctl;

  logic signed [31:0] x_origin_r;
  logic [30:0]        x_step_r;
  logic signed [31:0] y_origin_r;
  logic [30:0]        y_step_r;
  logic [7:0]         max_iter_r;

  logic [7:0]         col_r;
  logic [7:0]         row_r;
  logic signed [31:0] cr_r;
  logic signed [31:0] ci_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic [7:0]         count_r;
  logic signed [63:0] xx_r;
  logic signed [63:0] diff_r;
  logic               mag_r;

  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic               lim_hit;
  logic               done;
  logic               out_free;
  logic signed [31:0] x_nxt;
  logic signed [31:0] y_nxt;
  logic signed [63:0] xy_sh;
  logic [63:0]        mag_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= RST_X_ORIGIN;
      x_step_r   <= RST_X_STEP;
      y_origin_r <= RST_Y_ORIGIN;
      y_step_r   <= RST_Y_STEP;
      max_iter_r <= RST_MAX_ITER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin_r <= cfg_wdata;
        REG_X_STEP:   x_step_r   <= cfg_wdata[30:0];
        REG_Y_ORIGIN: y_origin_r <= cfg_wdata;
        REG_Y_STEP:   y_step_r   <= cfg_wdata[30:0];
        REG_MAX_ITER: max_iter_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .done     (done),
    .out_free (out_free),
    .ctl      (ctl)
  );

  always_comb begin
    case (ctl.mul_op)
      MOP_COLX: begin
        mul_a = {24'd0, col_r};
        mul_b = {1'b0, x_step_r};
      end
      MOP_ROWY: begin
        mul_a = {24'd0, row_r};
        mul_b = {1'b0, y_step_r};
      end
      MOP_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      MOP_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign mag_sum  = $unsigned(xx_r) + $unsigned(prod);
  assign lim_hit  = count_r >= max_iter_r;
  assign done     = lim_hit || mag_r;
  assign out_free = !out_valid_r || !out_stall;
  assign xy_sh    = prod >>> FRAC_BITS;
  assign x_nxt    = sat32((diff_r >>> FRAC_BITS) + 64'(cr_r));
  assign y_nxt    = sat32((xy_sh <<< 1) + 64'(ci_r));

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      col_r   <= in_data.column;
      row_r   <= in_data.row;
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
    end
    if (ctl.cap_cr) cr_r <= sat32(64'(x_origin_r) + prod);
    if (ctl.cap_ci) ci_r <= sat32(64'(y_origin_r) + prod);
    if (ctl.cap_xx) xx_r <= prod;
    if (ctl.cap_diff) begin
      diff_r <= xx_r - prod;
      mag_r  <= mag_sum >= MAG_LIMIT;
    end
    if (ctl.upd_en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      count_r <= count_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_r.iteration_count <= count_r;
      out_r.escaped         <= !lim_hit && mag_r;
    end
  end

  assign in_stall  = !ctl.idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/mbe_chk.sv -----
// Port checker for the escape counter, bound to the top level.
module mbe_chk import mbe_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left a result or busy state");

endmodule

bind mandelbrot_escape_count_core mbe_chk u_mbe_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/tb_mandelbrot_escape_count_core.sv -----
// Testbench for the Mandelbrot escape-time counter: random views, pixels and handshake gaps.
module tb_mandelbrot_escape_count_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  class escape_tally;
    logic signed [31:0] x_origin;
    logic [30:0]        x_step;
    logic signed [31:0] y_origin;
    logic [30:0]        y_step;
    logic [7:0]         max_iter;
    out_item_t          expected_counts[$];
    int                 errors;

    function new();
      x_origin = RST_X_ORIGIN;
      x_step   = RST_X_STEP;
      y_origin = RST_Y_ORIGIN;
      y_step   = RST_Y_STEP;
      max_iter = RST_MAX_ITER;
      errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_X_ORIGIN: x_origin = d;
        REG_X_STEP:   x_step   = d[30:0];
        REG_Y_ORIGIN: y_origin = d;
        REG_Y_STEP:   y_step   = d[30:0];
        REG_MAX_ITER: max_iter = d[7:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function out_item_t escape_count(in_item_t px);
      longint     cr, ci, x, y, xx, yy, xy, nx, m;
      logic [63:0] mag;
      out_item_t  r;
      cr = clamp_q(longint'(x_origin) + longint'(px.column) * longint'(x_step));
      ci = clamp_q(longint'(y_origin) + longint'(px.row) * longint'(y_step));
      x = 0;
      y = 0;
      r.iteration_count = 8'd0;
      r.escaped = 1'b0;
      while (r.iteration_count < max_iter) begin
        xx = x * x;
        yy = y * y;
        xy = x * y;
        mag = xx + yy;
        if (mag >= MAG_LIMIT) begin
          r.escaped = 1'b1;
          break;
        end
        nx = clamp_q(((xx - yy) >>> FRAC_BITS) + cr);
        m = xy >>> FRAC_BITS;
        y = clamp_q(m + m + ci);
        x = nx;
        r.iteration_count++;
      end
      return r;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void note_pixel(in_item_t px);
      expected_counts.push_back(escape_count(px));
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count %0d escaped %0b",
                                  got.iteration_count, got.escaped));
      end else begin
        want = expected_counts.pop_front();
        if (got.iteration_count !== want.iteration_count)
          report_mismatch($sformatf("iteration_count %0d, want %0d",
                                    got.iteration_count, want.iteration_count));
        if (got.escaped !== want.escaped)
          report_mismatch($sformatf("escaped %0b, want %0b", got.escaped, want.escaped));
      end
    endtask

    task flush_check();
      while (expected_counts.size() != 0) begin
        void'(expected_counts.pop_front());
        report_mismatch("result never arrived");
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_X_ORIGIN;
  logic [31:0] cfg_wdata = '0;

  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_left = 0;
  escape_tally tally;

  mandelbrot_escape_count_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_mandelbrot_escape_count_core: errors");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tally.check_result(out_data);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] col, input logic [7:0] row);
    in_item_t px;
    px.column = col;
    px.row = row;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally.note_pixel(px);
  endtask

  task automatic end_burst();
    int spin;
    spin = 0;
    in_valid <= 1'b0;
    while (tally.expected_counts.size() != 0 && spin < 40000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    tally.write_reg(idx, d);
  endtask

  task automatic set_view(input logic [31:0] xo, input logic [31:0] xs,
                          input logic [31:0] yo, input logic [31:0] ys,
                          input logic [31:0] lim);
    cfg_write(REG_X_ORIGIN, xo);
    cfg_write(REG_X_STEP, xs);
    cfg_write(REG_Y_ORIGIN, yo);
    cfg_write(REG_Y_STEP, ys);
    cfg_write(REG_MAX_ITER, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_view(input bit noisy);
    int xo, yo;
    logic [30:0] xs, ys;
    if (noisy) begin
      set_view($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255));
    end else begin
      xo = -671088640 + int'($urandom_range(0, 671088640));
      yo = -536870912 + int'($urandom_range(0, 536870912));
      xs = 31'($urandom_range(1 << 17, 1 << 23));
      ys = 31'($urandom_range(1 << 17, 1 << 23));
      set_view(xo, {1'($urandom), xs}, yo, {1'($urandom), ys},
               {24'($urandom), 8'($urandom_range(1, 60))});
    end
  endtask

  initial begin
    tally = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default view
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd16, 8'd11);
    send_pixel(8'd23, 8'd11);
    send_pixel(8'hAA, 8'h55);
    send_pixel(8'h55, 8'hAA);
    end_burst();

    // zero limit, writes to unused indices dropped
    for (int i = REG_MAX_ITER + 1; i < 8; i++) cfg_write(3'(i), $urandom);
    cfg_write(REG_MAX_ITER, 32'd0);
    cfg_we <= 1'b0;
    send_pixel(8'd16, 8'd11);
    send_pixel(8'd255, 8'd255);
    end_burst();

    cfg_write(REG_MAX_ITER, 32'd1);
    cfg_we <= 1'b0;
    send_pixel(8'd16, 8'd11);
    send_pixel(8'd0, 8'd0);
    end_burst();

    // saturating coordinates
    set_view(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd8);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd1);
    end_burst();

    // c at the origin never escapes
    set_view(32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'd255);
    send_pixel(8'd255, 8'd255);
    end_burst();

    set_view(RST_X_ORIGIN, {1'b0, RST_X_STEP}, RST_Y_ORIGIN, {1'b0, RST_Y_STEP}, 32'd255);
    send_pixel(8'd16, 8'd11);
    send_pixel(8'd23, 8'd11);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd200, 8'd100);
    end_burst();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 52;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 52;
        end
        default: begin
          in_idle_pct = 29;
          out_stall_pct = 29;
        end
      endcase
      pick_view(p == 3 || p == 6);
      if (p == 4) hold_left = 400;
      repeat (110) send_pixel(8'($urandom), 8'($urandom));
      end_burst();
    end

    repeat (20) @(posedge clk);
    tally.flush_check();
    if (tally.errors == 0) begin
      $display("tb_mandelbrot_escape_count_core: clean");
    end else begin
      $display("tb_mandelbrot_escape_count_core: errors");
    end
    $finish;
  end

endmodule
